// File: hdl/limit_order_book_matcher_unit_assert.svh
// ---------------------------------------------------------------------------
// limit order book matcher assertion macros
// shared property forms for the checker
// ---------------------------------------------------------------------------
`ifndef LIMIT_ORDER_BOOK_MATCHER_UNIT_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_UNIT_ASSERT_SVH

// same-cycle implication
`define LOBM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lobm check failed");

// next-cycle implication
`define LOBM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lobm check failed");

`endif

// File: hdl/lobm_pkg.sv
// ---------------------------------------------------------------------------
// lobm_pkg
// shared constants, widths and control types of the order book matcher
// ---------------------------------------------------------------------------
`default_nettype none

package lobm_pkg;

  localparam int BOOK_DEPTH_DEF = 16;
  localparam int MAX_FILLS      = 16;
  localparam int REF_W          = 16;
  localparam int QTY_W          = 32;
  localparam int PX_W           = 24;
  localparam int FILL_W         = $clog2(MAX_FILLS + 1);
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  // register index of last_px_init
  localparam logic REG_LAST_PX = 1'b0;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_REJ,
    EM_PEND,
    EM_PEND_LAST,
    EM_FIRST
  } emit_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      walk_pass;
    logic      walk_fill;
    logic      walk_end;
    logic      ins_start;
    logic      ins_shift;
    logic      ins_write;
    logic      rd_ins;
    emit_sel_t emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic own_full;
    logic walk_done;
    logic fill_hit;
    logic pend_valid;
    logic qty_zero;
    logic ins_done;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// File: hdl/lobm_ctrl.sv
// ---------------------------------------------------------------------------
// lobm_ctrl
// sequencer: reject check, book walk with fills, report emission, insertion
// ---------------------------------------------------------------------------
`default_nettype none

module lobm_ctrl (
  input  wire            clk,
  input  wire            rst,
  input  wire            order_valid,
  output logic           order_stall,
  input  lobm_pkg::stat_t stat,
  output lobm_pkg::cmd_t  cmd
);
  import lobm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REJ,
    ST_WALK,
    ST_EPEND,
    ST_EFIRST,
    ST_FIN,
    ST_INS,
    ST_SHIFT
  } state_t;

  state_t state, state_next;

  // only idle takes a new order
  assign order_stall = (state != ST_IDLE);

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (order_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = stat.own_full ? ST_REJ : ST_WALK;
      end
      ST_REJ: begin
        if (stat.out_free) begin
          cmd.emit   = EM_REJ;
          state_next = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (stat.walk_done) begin
          cmd.walk_end = 1'b1;
          state_next   = stat.pend_valid ? ST_FIN : ST_INS;
        end else if (stat.fill_hit) begin
          cmd.walk_fill = 1'b1;
          state_next    = stat.pend_valid ? ST_EPEND : ST_EFIRST;
        end else begin
          cmd.walk_pass = 1'b1;
        end
      end
      ST_EPEND: begin
        if (stat.out_free) begin
          cmd.emit   = EM_PEND;
          state_next = ST_EFIRST;
        end
      end
      ST_EFIRST: begin
        if (stat.out_free) begin
          cmd.emit   = EM_FIRST;
          state_next = ST_WALK;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.emit   = EM_PEND_LAST;
          state_next = ST_INS;
        end
      end
      ST_INS: begin
        if (stat.qty_zero) begin
          state_next = ST_IDLE;
        end else begin
          cmd.ins_start = 1'b1;
          state_next    = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd.rd_ins = 1'b1;
        if (stat.ins_done) begin
          cmd.ins_write = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          cmd.ins_shift = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/lobm_dpath.sv
// ---------------------------------------------------------------------------
// lobm_dpath
// both books, order registers, fill arithmetic and the report register
// ---------------------------------------------------------------------------
`default_nettype none

module lobm_dpath #(
  parameter int BOOK_DEPTH = lobm_pkg::BOOK_DEPTH_DEF
) (
  input  wire                        clk,
  input  wire                        rst,
  input  lobm_pkg::cmd_t             cmd,
  output lobm_pkg::stat_t            stat,
  input  wire                        cfg_we,
  input  wire [lobm_pkg::PX_W-1:0]   cfg_data,
  output logic [lobm_pkg::PX_W-1:0]  last_px_init,
  input  wire [lobm_pkg::REF_W-1:0]  order_ref,
  input  wire                        is_buy,
  input  wire                        is_market,
  input  wire [lobm_pkg::QTY_W-1:0]  order_qty,
  input  wire [lobm_pkg::PX_W-1:0]   limit_px,
  output logic                       report_valid,
  input  wire                        report_stall,
  output logic [lobm_pkg::REF_W-1:0] report_ref,
  output logic                       report_buy,
  output logic [lobm_pkg::QTY_W-1:0] fill_qty,
  output logic [lobm_pkg::PX_W-1:0]  fill_px,
  output logic                       status,
  output logic                       last_report
);
  import lobm_pkg::*;

  localparam int IW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int CW = $clog2(BOOK_DEPTH + 1);

  // books, side 1 bids, side 0 asks
  logic [REF_W-1:0] bk_ref [2][BOOK_DEPTH];
  logic             bk_mkt [2][BOOK_DEPTH];
  logic [PX_W-1:0]  bk_px  [2][BOOK_DEPTH];
  logic [QTY_W-1:0] bk_rem [2][BOOK_DEPTH];
  logic [CW-1:0]    cnt    [2];

  // order being worked
  logic [REF_W-1:0] ord_ref;
  logic             ord_buy;
  logic             ord_mkt;
  logic [QTY_W-1:0] ord_qty;
  logic [PX_W-1:0]  ord_px;
  logic [FILL_W-1:0] fills;
  logic [CW-1:0]    walk_i;
  logic [CW-1:0]    wr_w;
  logic [CW-1:0]    idx;
  logic [PX_W-1:0]  last_price;

  // latest fill and the held second report
  logic [REF_W-1:0] fill_oref;
  logic [QTY_W-1:0] fill_qty_r;
  logic [PX_W-1:0]  fill_px_r;
  logic             pend_valid;
  logic [REF_W-1:0] pend_ref;
  logic [QTY_W-1:0] pend_qty;
  logic [PX_W-1:0]  pend_px;

  logic             own, opp;
  logic             rd_side;
  logic [IW-1:0]    rd_idx;
  logic [REF_W-1:0] rd_ref;
  logic             rd_mkt;
  logic [PX_W-1:0]  rd_px;
  logic [QTY_W-1:0] rd_rem;
  logic [PX_W-1:0]  bpx, apx;
  logic             match;
  logic [QTY_W-1:0] fq, new_rem;
  logic [PX_W-1:0]  fp;
  logic             ahead;
  logic             out_free;
  logic [CW-1:0]    idx_m1;

  assign own    = ord_buy;
  assign opp    = ~ord_buy;
  assign idx_m1 = idx - CW'(1);

  // single read port: walk reads the opposite book, insertion its own
  assign rd_side = cmd.rd_ins ? own : opp;
  assign rd_idx  = cmd.rd_ins ? idx_m1[IW-1:0] : walk_i[IW-1:0];
  assign rd_ref  = bk_ref[rd_side][rd_idx];
  assign rd_mkt  = bk_mkt[rd_side][rd_idx];
  assign rd_px   = bk_px[rd_side][rd_idx];
  assign rd_rem  = bk_rem[rd_side][rd_idx];

  // match test and fill terms
  assign bpx     = ord_buy ? ord_px : rd_px;
  assign apx     = ord_buy ? rd_px : ord_px;
  assign match   = ord_mkt | rd_mkt | (bpx >= apx);
  assign fq      = (ord_qty < rd_rem) ? ord_qty : rd_rem;
  assign new_rem = rd_rem - fq;
  always_comb begin
    if (ord_mkt && rd_mkt) begin
      fp = last_price;
    end else if (rd_mkt) begin
      fp = ord_px;
    end else begin
      fp = rd_px;
    end
  end

  // new order goes ahead of this resting entry
  always_comb begin
    if (ord_mkt != rd_mkt) begin
      ahead = ord_mkt;
    end else if (ord_mkt) begin
      ahead = 1'b0;
    end else begin
      ahead = ord_buy ? (ord_px > rd_px) : (ord_px < rd_px);
    end
  end

  assign out_free = ~report_valid | ~report_stall;

  // status to the controller
  always_comb begin
    stat.own_full   = (cnt[own] == CW'(BOOK_DEPTH));
    stat.walk_done  = (walk_i == cnt[opp]);
    stat.fill_hit   = (rd_rem != '0) && match && (ord_qty != '0) &&
                      (fills < FILL_W'(MAX_FILLS));
    stat.pend_valid = pend_valid;
    stat.qty_zero   = (ord_qty == '0);
    stat.ins_done   = (idx == '0) || ~ahead;
    stat.out_free   = out_free;
  end

  // book storage, one write a cycle
  always_ff @(posedge clk) begin
    if (cmd.walk_pass && (rd_rem != '0)) begin
      bk_ref[opp][wr_w[IW-1:0]] <= rd_ref;
      bk_mkt[opp][wr_w[IW-1:0]] <= rd_mkt;
      bk_px[opp][wr_w[IW-1:0]]  <= rd_px;
      bk_rem[opp][wr_w[IW-1:0]] <= rd_rem;
    end else if (cmd.walk_fill && (new_rem != '0)) begin
      bk_ref[opp][wr_w[IW-1:0]] <= rd_ref;
      bk_mkt[opp][wr_w[IW-1:0]] <= rd_mkt;
      bk_px[opp][wr_w[IW-1:0]]  <= rd_px;
      bk_rem[opp][wr_w[IW-1:0]] <= new_rem;
    end else if (cmd.ins_shift) begin
      bk_ref[own][idx[IW-1:0]] <= rd_ref;
      bk_mkt[own][idx[IW-1:0]] <= rd_mkt;
      bk_px[own][idx[IW-1:0]]  <= rd_px;
      bk_rem[own][idx[IW-1:0]] <= rd_rem;
    end else if (cmd.ins_write) begin
      bk_ref[own][idx[IW-1:0]] <= ord_ref;
      bk_mkt[own][idx[IW-1:0]] <= ord_mkt;
      bk_px[own][idx[IW-1:0]]  <= ord_px;
      bk_rem[own][idx[IW-1:0]] <= ord_qty;
    end
  end

  // counts, last price, configured price and pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt[0]       <= '0;
      cnt[1]       <= '0;
      last_price   <= '0;
      last_px_init <= '0;
      pend_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        last_px_init <= cfg_data;
        last_price   <= cfg_data;
      end
      if (cmd.walk_fill) begin
        last_price <= fp;
      end
      if (cmd.walk_end) begin
        cnt[opp] <= wr_w;
      end
      if (cmd.ins_write) begin
        cnt[own] <= cnt[own] + CW'(1);
      end
      if (cmd.load || (cmd.emit == EM_PEND_LAST)) begin
        pend_valid <= 1'b0;
      end else if (cmd.emit == EM_FIRST) begin
        pend_valid <= 1'b1;
      end
    end
  end

  // order and walk payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ord_ref <= order_ref;
      ord_buy <= is_buy;
      ord_mkt <= is_market;
      ord_qty <= order_qty;
      ord_px  <= is_market ? '0 : limit_px;
      fills   <= '0;
      walk_i  <= '0;
      wr_w    <= '0;
    end
    if (cmd.walk_pass) begin
      walk_i <= walk_i + CW'(1);
      if (rd_rem != '0) begin
        wr_w <= wr_w + CW'(1);
      end
    end
    if (cmd.walk_fill) begin
      walk_i     <= walk_i + CW'(1);
      if (new_rem != '0) begin
        wr_w <= wr_w + CW'(1);
      end
      ord_qty    <= ord_qty - fq;
      fills      <= fills + FILL_W'(1);
      fill_oref  <= rd_ref;
      fill_qty_r <= fq;
      fill_px_r  <= fp;
    end
    if (cmd.ins_start) begin
      idx <= cnt[own];
    end
    if (cmd.ins_shift) begin
      idx <= idx_m1;
    end
    if (cmd.emit == EM_FIRST) begin
      pend_ref <= ord_buy ? fill_oref : ord_ref;
      pend_qty <= fill_qty_r;
      pend_px  <= fill_px_r;
    end
  end

  // report output register
  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (cmd.emit != EM_NONE) begin
      report_valid <= 1'b1;
    end else if (~report_stall) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      EM_REJ: begin
        report_ref  <= ord_ref;
        report_buy  <= ord_buy;
        fill_qty    <= '0;
        fill_px     <= '0;
        status      <= 1'b1;
        last_report <= 1'b1;
      end
      EM_PEND, EM_PEND_LAST: begin
        report_ref  <= pend_ref;
        report_buy  <= 1'b0;
        fill_qty    <= pend_qty;
        fill_px     <= pend_px;
        status      <= 1'b0;
        last_report <= (cmd.emit == EM_PEND_LAST);
      end
      EM_FIRST: begin
        report_ref  <= ord_buy ? ord_ref : fill_oref;
        report_buy  <= 1'b1;
        fill_qty    <= fill_qty_r;
        fill_px     <= fill_px_r;
        status      <= 1'b0;
        last_report <= 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/limit_order_book_matcher_unit.sv
// ---------------------------------------------------------------------------
// limit_order_book_matcher_unit
// price/time priority order book with matching and fill reports
// ---------------------------------------------------------------------------
// One order is worked at a time; order_stall stays high from acceptance until
// the order is fully done. An order holds order_stall high through the check,
// the walk of the opposite book, the two reports of each fill and, when a
// remainder rests, the shift of own-book entries on insertion, plus any
// report_stall time; the single read and write port shared by both books
// sets the per-entry cost. A full own book gets its one reject report from
// the reject state after the check, with no walk. The second report of each
// fill is held back until the next fill or the end of the walk so that
// last_report can be flagged on it.
// ---------------------------------------------------------------------------
`default_nettype none

module limit_order_book_matcher_unit #(
  parameter int BOOK_DEPTH = lobm_pkg::BOOK_DEPTH_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire [lobm_pkg::ADDR_W-1:0]  paddr,
  input  wire [lobm_pkg::DATA_W-1:0]  pwdata,
  output logic [lobm_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  wire                         order_valid,
  output logic                        order_stall,
  input  wire [lobm_pkg::REF_W-1:0]   order_ref,
  input  wire                         is_buy,
  input  wire                         is_market,
  input  wire [lobm_pkg::QTY_W-1:0]   order_qty,
  input  wire [lobm_pkg::PX_W-1:0]    limit_px,
  output logic                        report_valid,
  input  wire                         report_stall,
  output logic [lobm_pkg::REF_W-1:0]  report_ref,
  output logic                        report_buy,
  output logic [lobm_pkg::QTY_W-1:0]  fill_qty,
  output logic [lobm_pkg::PX_W-1:0]   fill_px,
  output logic                        status,
  output logic                        last_report
);
  import lobm_pkg::*;

  cmd_t            cmd;
  stat_t           stat;
  logic            cfg_we;
  logic [PX_W-1:0] last_px_init;

  // register port decode
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[2] == REG_LAST_PX);
  assign prdata = (paddr[2] == REG_LAST_PX) ?
                  {{(DATA_W - PX_W){1'b0}}, last_px_init} : '0;

  lobm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .order_valid (order_valid),
    .order_stall (order_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  lobm_dpath #(
    .BOOK_DEPTH (BOOK_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_data     (pwdata[PX_W-1:0]),
    .last_px_init (last_px_init),
    .order_ref    (order_ref),
    .is_buy       (is_buy),
    .is_market    (is_market),
    .order_qty    (order_qty),
    .limit_px     (limit_px),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report_ref   (report_ref),
    .report_buy   (report_buy),
    .fill_qty     (fill_qty),
    .fill_px      (fill_px),
    .status       (status),
    .last_report  (last_report)
  );

endmodule

`default_nettype wire

// File: hdl/lobm_checker.sv
// ---------------------------------------------------------------------------
// lobm_checker
// port-level checks of the order book matcher, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "limit_order_book_matcher_unit_assert.svh"

module lobm_checker (
  input wire                         clk,
  input wire                         rst,
  input wire                         order_valid,
  input wire                         order_stall,
  input wire                         report_valid,
  input wire                         report_stall,
  input wire [lobm_pkg::REF_W-1:0]   report_ref,
  input wire                         report_buy,
  input wire [lobm_pkg::QTY_W-1:0]   fill_qty,
  input wire [lobm_pkg::PX_W-1:0]    fill_px,
  input wire                         status,
  input wire                         last_report
);

  // an accepted order keeps the block busy in the next cycle
  `LOBM_ASSERT_NXT(a_busy_after_accept, clk, rst, order_valid && !order_stall, order_stall)

  // a stalled report holds
  `LOBM_ASSERT_NXT(a_report_hold, clk, rst, report_valid && report_stall, report_valid && $stable(report_ref) && $stable(fill_qty) && $stable(fill_px))

  // a reject carries no fill and ends the order
  `LOBM_ASSERT_IMP(a_reject_form, clk, rst, report_valid && status, fill_qty == '0 && fill_px == '0 && last_report)

  // the purchase report of a fill is never the final one
  `LOBM_ASSERT_IMP(a_buy_not_last, clk, rst, report_valid && !status && report_buy, !last_report)

endmodule

bind limit_order_book_matcher_unit lobm_checker u_lobm_checker (.*);

`default_nettype wire
